// ===== rtl/rc_pulse_capture_glitch_reject_core_assert.svh =====
// assertion macros used by the checker file
`ifndef RC_PULSE_CAPTURE_GLITCH_REJECT_CORE_ASSERT_SVH
`define RC_PULSE_CAPTURE_GLITCH_REJECT_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RCPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcpc assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define RCPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcpc assertion failed");

`endif

// ===== rtl/rcpc_pkg.sv =====
// package: field widths, reset values, codes and shared structs of the capture core
package rcpc_pkg;

   localparam int COUNT_W    = 16;
   localparam int CHAN_W     = 2;
   localparam int HOLD_W     = 5;
   localparam int WRAP_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [COUNT_W-1:0] JUMP_LIMIT_RESET    = 16'd800;
   localparam logic [COUNT_W-1:0] ARM_THRESHOLD_RESET = 16'd4200;
   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET    = 5'd20;
   localparam logic [WRAP_W-1:0]  WRAP_ADD_RESET      = 17'd65535;
   localparam logic [COUNT_W-1:0] WIDTH_RESET         = 16'd3500;
   localparam logic [HOLD_W-1:0]  HOLD_MAX            = 5'd31;
   localparam logic [CHAN_W-1:0]  ARM_CHANNEL         = 2'd1;

   typedef enum logic {
      OP_CAPTURE = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JUMP_LIMIT    = 2'd0,
      CSR_ARM_THRESHOLD = 2'd1,
      CSR_HOLD_TICKS    = 2'd2,
      CSR_WRAP_ADD      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] jump_limit;
      logic [COUNT_W-1:0] arm_threshold;
      logic [HOLD_W-1:0]  hold_ticks;
      logic [WRAP_W-1:0]  wrap_add;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [CHAN_W-1:0]  channel;
      logic [COUNT_W-1:0] width;
   } width_evt_type;

endpackage

// ===== rtl/rcpc_ifs.sv =====
// handshake interfaces for the request, response and register-write channels

interface rcpc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [rcpc_pkg::CHAN_W-1:0]      channel;
   logic [rcpc_pkg::COUNT_W-1:0]     capture_count;

   modport source (output valid, output op, output channel, output capture_count,
                   input ready);
   modport sink   (input valid, input op, input channel, input capture_count,
                   output ready);
endinterface

interface rcpc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             width_valid;
   logic [rcpc_pkg::CHAN_W-1:0]      width_channel;
   logic [rcpc_pkg::COUNT_W-1:0]     pulse_width;
   logic                             remote_mode;
   logic                             mode_entered;

   modport source (output valid, output width_valid, output width_channel,
                   output pulse_width, output remote_mode, output mode_entered,
                   input ready);
   modport sink   (input valid, input width_valid, input width_channel,
                   input pulse_width, input remote_mode, input mode_entered,
                   output ready);
endinterface

interface rcpc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rcpc_pkg::CSR_IDX_W-1:0]    index;
   logic [rcpc_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/rcpc_csr.sv =====
// configuration register file: write decode and reset values
module rcpc_csr (
   input  logic                clock,
   input  logic                reset,
   rcpc_csr_if.sink            csr_chan,
   output rcpc_pkg::cfg_type   cfg
);

   rcpc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (rcpc_pkg::csr_index_type'(csr_chan.index))
            rcpc_pkg::CSR_JUMP_LIMIT:
               cfg_in.jump_limit = csr_chan.wdata[rcpc_pkg::COUNT_W-1:0];
            rcpc_pkg::CSR_ARM_THRESHOLD:
               cfg_in.arm_threshold = csr_chan.wdata[rcpc_pkg::COUNT_W-1:0];
            rcpc_pkg::CSR_HOLD_TICKS:
               cfg_in.hold_ticks = csr_chan.wdata[rcpc_pkg::HOLD_W-1:0];
            rcpc_pkg::CSR_WRAP_ADD:
               cfg_in.wrap_add = csr_chan.wdata[rcpc_pkg::WRAP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_limit    <= rcpc_pkg::JUMP_LIMIT_RESET;
         cfg_ff.arm_threshold <= rcpc_pkg::ARM_THRESHOLD_RESET;
         cfg_ff.hold_ticks    <= rcpc_pkg::HOLD_TICKS_RESET;
         cfg_ff.wrap_add      <= rcpc_pkg::WRAP_ADD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/rcpc_width.sv =====
// per-channel edge tracking, width measurement and glitch rejection
module rcpc_width #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          capture,
   input  logic                          commit,
   input  logic [rcpc_pkg::CHAN_W-1:0]   channel,
   input  logic [rcpc_pkg::COUNT_W-1:0]  count,
   input  rcpc_pkg::cfg_type             cfg,
   output rcpc_pkg::width_evt_type       evt
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [3:0] NUM_CH = 4'(NUM_CHANNELS);
   localparam int RAW_W = rcpc_pkg::COUNT_W + 2;

   logic                         await_fall_ff [NUM_CHANNELS];
   logic [rcpc_pkg::COUNT_W-1:0] rise_ff       [NUM_CHANNELS];
   logic [rcpc_pkg::COUNT_W-1:0] last_ff       [NUM_CHANNELS];

   logic [2:0]                   chan_ext;
   logic [IDX_W-1:0]             idx;
   logic                         in_range;
   logic [rcpc_pkg::COUNT_W-1:0] rise;
   logic [rcpc_pkg::COUNT_W-1:0] last;
   logic [RAW_W-1:0]             raw;
   logic [rcpc_pkg::COUNT_W-1:0] sat;
   logic [rcpc_pkg::COUNT_W-1:0] diff;
   logic [rcpc_pkg::COUNT_W-1:0] filt;
   logic                         is_fall;

   assign chan_ext = {1'b0, channel};
   assign idx      = chan_ext[IDX_W-1:0];
   assign in_range = {1'b0, chan_ext} < NUM_CH;
   assign rise     = rise_ff[idx];
   assign last     = last_ff[idx];
   assign is_fall  = capture && in_range && await_fall_ff[idx];

   // raw width is exact, then clamped into the count range; a change beyond the jump limit keeps the last width
   always_comb begin
      raw = {2'b00, count} - {2'b00, rise};
      if (count < rise) begin
         raw = raw + {1'b0, cfg.wrap_add};
      end
      if (raw[RAW_W-1]) begin
         sat = '0;
      end else if (raw[RAW_W-2]) begin
         sat = '1;
      end else begin
         sat = raw[rcpc_pkg::COUNT_W-1:0];
      end
      diff = (sat > last) ? (sat - last) : (last - sat);
      filt = (diff > cfg.jump_limit) ? last : sat;
   end

   assign evt.valid   = is_fall;
   assign evt.channel = channel;
   assign evt.width   = is_fall ? filt : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            await_fall_ff[i] <= 1'b0;
            rise_ff[i]       <= '0;
            last_ff[i]       <= rcpc_pkg::WIDTH_RESET;
         end
      end else if (commit && capture && in_range) begin
         if (!await_fall_ff[idx]) begin
            rise_ff[idx]       <= count;
            await_fall_ff[idx] <= 1'b1;
         end else begin
            last_ff[idx]       <= filt;
            await_fall_ff[idx] <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/rcpc_mode.sv =====
// stick-hold detector: stick flag, hold counter and remote mode
module rcpc_mode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  logic                     tick,
   input  rcpc_pkg::width_evt_type  evt,
   input  rcpc_pkg::cfg_type        cfg,
   output logic                     remote_next,
   output logic                     entered
);

   logic                        stick_ff;
   logic [rcpc_pkg::HOLD_W-1:0] hold_ff;
   logic                        remote_ff;
   logic [rcpc_pkg::HOLD_W-1:0] hold_in;
   logic                        arm_hit;

   always_comb begin
      if (stick_ff) begin
         hold_in = (hold_ff < rcpc_pkg::HOLD_MAX) ? hold_ff + 5'd1 : hold_ff;
      end else begin
         hold_in = '0;
      end
   end

   assign entered     = tick && !remote_ff && (hold_in > cfg.hold_ticks);
   assign remote_next = remote_ff || entered;
   assign arm_hit     = evt.valid && (evt.channel == rcpc_pkg::ARM_CHANNEL)
                        && (evt.width > cfg.arm_threshold);

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_ff  <= 1'b0;
         hold_ff   <= '0;
         remote_ff <= 1'b0;
      end else if (commit) begin
         if (tick) begin
            if (!remote_ff) begin
               hold_ff <= hold_in;
            end
            remote_ff <= remote_next;
            stick_ff  <= 1'b0;
         end else if (arm_hit) begin
            stick_ff <= 1'b1;
         end
      end
   end

endmodule

// ===== rtl/rc_pulse_capture_glitch_reject_core.sv =====
// top level of the rc pulse-width capture core with glitch rejection
//
// channels
//   req_chan  : capture requests (op capture: channel + timer count) and mode-check ticks
//   rsp_chan  : exactly one response per request, in request order
//   csr_chan  : register writes (jump limit, arm threshold, hold ticks, wrap add),
//               always ready, only to be written while no request is in flight
// timing
//   a request waits in the input register until the output register is free, then
//   its response is loaded into the output register and rsp valid rises
//   one request per cycle sustained while rsp_ready stays high; each request only reads
//   and updates the per-channel and mode state in one pass, and the next one sees the result
// reset
//   synchronous, active high: both stages empty, channels wait for a rising edge,
//   last widths back to 3500, stick flag, hold count and remote mode cleared,
//   registers to their defaults
// back-pressure
//   with rsp_ready low the output register holds; the input register still
//   takes one more request, after which req_ready drops until the response moves
module rc_pulse_capture_glitch_reject_core #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   rcpc_req_if.sink    req_chan,
   rcpc_rsp_if.source  rsp_chan,
   rcpc_csr_if.sink    csr_chan
);

   rcpc_pkg::cfg_type        cfg;
   rcpc_pkg::width_evt_type  evt;

   // input register stage
   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic [rcpc_pkg::CHAN_W-1:0]   in_chan_ff;
   logic [rcpc_pkg::COUNT_W-1:0]  in_count_ff;

   // output register stage
   logic                          out_valid_ff;
   logic                          out_width_valid_ff;
   logic [rcpc_pkg::CHAN_W-1:0]   out_chan_ff;
   logic [rcpc_pkg::COUNT_W-1:0]  out_width_ff;
   logic                          out_remote_ff;
   logic                          out_entered_ff;

   logic advance;
   logic is_tick;
   logic is_capture;
   logic remote_next;
   logic entered;

   // the request in the input register retires when the output slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign is_tick    = in_valid_ff && (in_op_ff == rcpc_pkg::OP_TICK);
   assign is_capture = in_valid_ff && (in_op_ff == rcpc_pkg::OP_CAPTURE);

   rcpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rcpc_width #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_width (
      .clock   (clock),
      .reset   (reset),
      .capture (is_capture),
      .commit  (advance),
      .channel (in_chan_ff),
      .count   (in_count_ff),
      .cfg     (cfg),
      .evt     (evt)
   );

   rcpc_mode u_mode (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .tick        (is_tick),
      .evt         (evt),
      .cfg         (cfg),
      .remote_next (remote_next),
      .entered     (entered)
   );

   // input register: control reset, payload free-running on load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_op_ff    <= req_chan.op;
         in_chan_ff  <= req_chan.channel;
         in_count_ff <= req_chan.capture_count;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_width_valid_ff <= evt.valid;
         // tick responses report channel zero
         out_chan_ff        <= is_tick ? '0 : in_chan_ff;
         out_width_ff       <= evt.width;
         out_remote_ff      <= remote_next;
         out_entered_ff     <= entered;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.width_valid   = out_width_valid_ff;
   assign rsp_chan.width_channel = out_chan_ff;
   assign rsp_chan.pulse_width   = out_width_ff;
   assign rsp_chan.remote_mode   = out_remote_ff;
   assign rsp_chan.mode_entered  = out_entered_ff;

endmodule

// ===== rtl/rcpc_checker.sv =====
// port-level checks on the capture core, attached to the top level by bind
`include "rc_pulse_capture_glitch_reject_core_assert.svh"

module rcpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          width_valid,
   input logic [rcpc_pkg::COUNT_W-1:0]  pulse_width,
   input logic                          remote_mode,
   input logic                          mode_entered
);

   // a stalled response stays valid and keeps its width flag, width and remote mode
   `RCPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(width_valid) && $stable(pulse_width) && $stable(remote_mode))

   // no width reported without a falling edge
   `RCPC_ASSERT_SAME(a_width_zero, clock, reset, rsp_valid && !width_valid,
      pulse_width == '0)

   // entering remote mode is a tick, never a width report
   `RCPC_ASSERT_SAME(a_entered, clock, reset, rsp_valid && mode_entered,
      remote_mode && !width_valid)

   // remote mode is only left by reset
   `RCPC_ASSERT_NEXT(a_remote_sticky, clock, reset, rsp_valid && remote_mode,
      !rsp_valid || remote_mode)

endmodule

bind rc_pulse_capture_glitch_reject_core rcpc_checker u_rcpc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .width_valid  (rsp_chan.width_valid),
   .pulse_width  (rsp_chan.pulse_width),
   .remote_mode  (rsp_chan.remote_mode),
   .mode_entered (rsp_chan.mode_entered)
);

// ===== test/rc_pulse_capture_glitch_reject_core_tb.sv =====
// testbench for the rc pulse capture core: random and directed requests checked by a predictor
`timescale 1ns / 100ps

module rc_pulse_capture_glitch_reject_core_tb;

   localparam int CHANNELS     = 4;
   localparam int CLOCK_PERIOD = 20;

   // one expected response: width event plus the mode flags
   typedef struct {
      rcpc_pkg::width_evt_type evt;
      logic                    remote;
      logic                    entered;
   } capture_result_type;

   // behavioural copy of the capture core: registers, channel state, mode detector
   class pulse_width_tracker_type;
      rcpc_pkg::cfg_type  regs;
      logic               await_fall [CHANNELS];
      logic [15:0]        rise_count [CHANNELS];
      logic [15:0]        last_width [CHANNELS];
      logic               stick_pushed;
      logic [4:0]         hold_count;
      logic               in_remote;
      capture_result_type pending [$];
      int                 errors;
      int                 requests;
      int                 widths;
      int                 ticks;

      function new();
         regs.jump_limit    = rcpc_pkg::JUMP_LIMIT_RESET;
         regs.arm_threshold = rcpc_pkg::ARM_THRESHOLD_RESET;
         regs.hold_ticks    = rcpc_pkg::HOLD_TICKS_RESET;
         regs.wrap_add      = rcpc_pkg::WRAP_ADD_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            await_fall[i] = 1'b0;
            rise_count[i] = '0;
            last_width[i] = rcpc_pkg::WIDTH_RESET;
         end
         stick_pushed = 1'b0;
         hold_count   = '0;
         in_remote    = 1'b0;
         errors       = 0;
         requests     = 0;
         widths       = 0;
         ticks        = 0;
      endfunction

      function void write_register(rcpc_pkg::csr_index_type idx,
                                   logic [rcpc_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rcpc_pkg::CSR_JUMP_LIMIT:    regs.jump_limit    = value[rcpc_pkg::COUNT_W-1:0];
            rcpc_pkg::CSR_ARM_THRESHOLD: regs.arm_threshold = value[rcpc_pkg::COUNT_W-1:0];
            rcpc_pkg::CSR_HOLD_TICKS:    regs.hold_ticks    = value[rcpc_pkg::HOLD_W-1:0];
            rcpc_pkg::CSR_WRAP_ADD:      regs.wrap_add      = value[rcpc_pkg::WRAP_W-1:0];
            default: ;
         endcase
      endfunction

      // works out the response of one accepted request and queues it
      function void take_request(rcpc_pkg::op_type op, logic [rcpc_pkg::CHAN_W-1:0] ch,
                                 logic [rcpc_pkg::COUNT_W-1:0] cnt);
         capture_result_type res;
         int                 raw;
         logic [15:0]        w;
         logic [15:0]        diff;
         res.evt     = '0;
         res.entered = 1'b0;
         requests++;
         if (op == rcpc_pkg::OP_CAPTURE) begin
            res.evt.channel = ch;
            if (ch < CHANNELS) begin
               if (!await_fall[ch]) begin
                  rise_count[ch] = cnt;
                  await_fall[ch] = 1'b1;
               end else begin
                  raw = int'(cnt) - int'(rise_count[ch]);
                  if (cnt < rise_count[ch])
                     raw += int'(regs.wrap_add);
                  if (raw < 0)
                     raw = 0;
                  if (raw > 65535)
                     raw = 65535;
                  w    = raw[15:0];
                  diff = (w > last_width[ch]) ? w - last_width[ch] : last_width[ch] - w;
                  if (diff > regs.jump_limit)
                     w = last_width[ch];
                  last_width[ch] = w;
                  if (ch == rcpc_pkg::ARM_CHANNEL && w > regs.arm_threshold)
                     stick_pushed = 1'b1;
                  await_fall[ch] = 1'b0;
                  res.evt.valid  = 1'b1;
                  res.evt.width  = w;
                  widths++;
               end
            end
         end else begin
            ticks++;
            if (!in_remote) begin
               if (stick_pushed) begin
                  if (hold_count < rcpc_pkg::HOLD_MAX)
                     hold_count++;
               end else begin
                  hold_count = '0;
               end
               if (hold_count > regs.hold_ticks) begin
                  in_remote   = 1'b1;
                  res.entered = 1'b1;
               end
            end
            stick_pushed = 1'b0;
         end
         res.remote = in_remote;
         pending.push_back(res);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void match_response(logic wv, logic [rcpc_pkg::CHAN_W-1:0] wc,
                                   logic [rcpc_pkg::COUNT_W-1:0] pw, logic rm, logic me);
         capture_result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, expected none, actual width %0d",
                     $time, pw);
            return;
         end
         want = pending.pop_front();
         check_field("width_valid", 16'(want.evt.valid), 16'(wv));
         check_field("width_channel", 16'(want.evt.channel), 16'(wc));
         check_field("pulse_width", want.evt.width, pw);
         check_field("remote_mode", 16'(want.remote), 16'(rm));
         check_field("mode_entered", 16'(want.entered), 16'(me));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic bursts_on = 1'b1;
   logic gen_await [CHANNELS] = '{default: 1'b0};
   int   stall_left = 0;
   int   settings_used = 0;

   pulse_width_tracker_type tracker = new();

   rcpc_req_if req_if ();
   rcpc_rsp_if rsp_if ();
   rcpc_csr_if csr_if ();

   rc_pulse_capture_glitch_reject_core #(.NUM_CHANNELS(CHANNELS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watch all three handshakes at the rising edge, values as they stood before it
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            tracker.take_request(rcpc_pkg::op_type'(req_if.op), req_if.channel,
                                 req_if.capture_count);
         if (rsp_if.valid && rsp_if.ready)
            tracker.match_response(rsp_if.width_valid, rsp_if.width_channel,
                                   rsp_if.pulse_width, rsp_if.remote_mode,
                                   rsp_if.mode_entered);
         if (csr_if.valid && csr_if.ready)
            tracker.write_register(rcpc_pkg::csr_index_type'(csr_if.index), csr_if.wdata);
      end
   end

   // response back-pressure: random stall bursts while bursts are on
   always @(posedge clock) begin
      if (reset || !bursts_on) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // valid stays high from one request to the next unless a gap is drawn
   task automatic send_request(rcpc_pkg::op_type op, int ch, int cnt);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.op            <= op;
      req_if.channel       <= ch[rcpc_pkg::CHAN_W-1:0];
      req_if.capture_count <= cnt[rcpc_pkg::COUNT_W-1:0];
      if (op == rcpc_pkg::OP_CAPTURE)
         gen_await[ch] = !gen_await[ch];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // lower valid and wait until every response is back and the pipeline is empty
   task automatic quiesce();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(rcpc_pkg::csr_index_type idx, int value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value[rcpc_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic apply_settings(int jump, int arm, int hold, int wrap);
      write_register(rcpc_pkg::CSR_JUMP_LIMIT, jump);
      write_register(rcpc_pkg::CSR_ARM_THRESHOLD, arm);
      write_register(rcpc_pkg::CSR_HOLD_TICKS, hold);
      write_register(rcpc_pkg::CSR_WRAP_ADD, wrap);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // a width close to the channel's last one, mostly inside the jump limit
   function automatic int near_width(int ch);
      int last;
      int span;
      last = int'(tracker.last_width[ch]);
      span = int'(tracker.regs.jump_limit);
      if (span > 3000)
         span = 3000;
      last = last - span + int'($urandom_range(0, 2 * span));
      if (last < 0)
         last = 0;
      if (last > 65535)
         last = 65535;
      return last;
   endfunction

   // steps the arming channel towards a width just above the threshold
   function automatic int stick_width();
      int last;
      int lim;
      int target;
      last   = int'(tracker.last_width[rcpc_pkg::ARM_CHANNEL]);
      lim    = int'(tracker.regs.jump_limit);
      target = int'(tracker.regs.arm_threshold) + 1 + int'($urandom_range(0, 40));
      if (target > last + lim)
         target = last + lim;
      if (target > 65535)
         target = 65535;
      return target;
   endfunction

   // rise then fall on one channel; closes a half-open pulse first
   task automatic send_pulse(int ch, int w);
      int rise;
      if (gen_await[ch])
         send_request(rcpc_pkg::OP_CAPTURE, ch, $urandom_range(0, 65535));
      rise = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 65535)
                                         : $urandom_range(0, 65535);
      send_request(rcpc_pkg::OP_CAPTURE, ch, rise);
      send_request(rcpc_pkg::OP_CAPTURE, ch, (rise + w) & 16'hffff);
   endtask

   task automatic run_traffic(int count);
      int sent;
      int kind;
      int runs;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // clean pulse close to the last width
            runs = $urandom_range(0, CHANNELS - 1);
            send_pulse(runs, near_width(runs));
            sent += 2;
         end else if (kind < 65) begin
            // stick held over a run of ticks, now and then long enough to saturate
            runs = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 4);
            repeat (runs) begin
               send_pulse(rcpc_pkg::ARM_CHANNEL, stick_width());
               send_request(rcpc_pkg::OP_TICK, $urandom_range(0, 3), $urandom_range(0, 65535));
               sent += 3;
            end
         end else if (kind < 75) begin
            send_request(rcpc_pkg::OP_TICK, $urandom_range(0, 3), $urandom_range(0, 65535));
            sent++;
         end else if (kind < 87) begin
            // stray edge, leaves the channel out of step
            send_request(rcpc_pkg::OP_CAPTURE, $urandom_range(0, 3), $urandom_range(0, 65535));
            sent++;
         end else begin
            // glitch: width anywhere
            send_pulse($urandom_range(0, CHANNELS - 1), $urandom_range(0, 65535));
            sent += 2;
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.op            <= rcpc_pkg::OP_CAPTURE;
      req_if.channel       <= '0;
      req_if.capture_count <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= rcpc_pkg::CSR_JUMP_LIMIT;
      csr_if.wdata         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings
      send_request(rcpc_pkg::OP_CAPTURE, 0, 0);        // full-scale width, rejected as a jump
      send_request(rcpc_pkg::OP_CAPTURE, 0, 65535);
      send_request(rcpc_pkg::OP_CAPTURE, 0, 65535);    // wrapped count down to zero width
      send_request(rcpc_pkg::OP_CAPTURE, 0, 0);
      send_request(rcpc_pkg::OP_CAPTURE, 1, 64000);    // wrapped pulse above the threshold
      send_request(rcpc_pkg::OP_CAPTURE, 1, 2700);
      send_request(rcpc_pkg::OP_TICK, 3, 65535);       // tick ignores channel and count
      send_request(rcpc_pkg::OP_CAPTURE, 1, 100);      // width equal to the threshold
      send_request(rcpc_pkg::OP_CAPTURE, 1, 4300);
      send_request(rcpc_pkg::OP_TICK, 0, 0);           // no push, hold count cleared
      send_request(rcpc_pkg::OP_CAPTURE, 2, 1000);     // change exactly at the jump limit
      send_request(rcpc_pkg::OP_CAPTURE, 2, 5300);
      send_request(rcpc_pkg::OP_CAPTURE, 3, 20000);    // one past the jump limit
      send_request(rcpc_pkg::OP_CAPTURE, 3, 22699);
      send_request(rcpc_pkg::OP_CAPTURE, 3, 7);        // equal counts
      send_request(rcpc_pkg::OP_CAPTURE, 3, 7);
      send_request(rcpc_pkg::OP_CAPTURE, 2, 40000);
      send_request(rcpc_pkg::OP_CAPTURE, 2, 44301);
      send_request(rcpc_pkg::OP_TICK, 1, 16'h5555);
      send_request(rcpc_pkg::OP_CAPTURE, 1, 16'h5555);
      send_request(rcpc_pkg::OP_CAPTURE, 1, 26145);
      send_request(rcpc_pkg::OP_TICK, 2, 16'haaaa);
      quiesce();

      // hold ticks at full scale: counter saturates, mode never entered
      apply_settings(65535, 0, 31, 65536);
      run_traffic(130);
      quiesce();

      // no width change accepted, nothing arms, no wrap correction
      apply_settings(0, 65535, 30, 0);
      run_traffic(100);
      quiesce();

      apply_settings($urandom_range(100, 3000), $urandom_range(3000, 6000),
                     $urandom_range(21, 30), 131071);
      run_traffic(120);
      quiesce();

      // zero hold: first pushed tick enters remote mode
      apply_settings($urandom_range(0, 65535), $urandom_range(1000, 5000), 0, 65535);
      run_traffic(120);
      quiesce();

      // closing stretch without idling on either side
      bursts_on = 1'b0;
      apply_settings($urandom_range(400, 1200), 4200, 20, $urandom_range(0, 131071));
      run_traffic(110);
      quiesce();

      $display("covered %0d requests under %0d register settings", tracker.requests,
               settings_used + 1);
      $display("%0d widths reported, %0d ticks, remote mode reached: %0d", tracker.widths,
               tracker.ticks, tracker.in_remote);
      if (tracker.errors == 0)
         $display("rc_pulse_capture_glitch_reject_core test passed");
      else
         $display("rc_pulse_capture_glitch_reject_core test failed");
      $finish;
   end

   // hang guard
   initial begin
      #5000000;
      $display("rc_pulse_capture_glitch_reject_core test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcpc_pkg.sv
rtl/rcpc_ifs.sv
rtl/rcpc_csr.sv
rtl/rcpc_width.sv
rtl/rcpc_mode.sv
rtl/rc_pulse_capture_glitch_reject_core.sv
rtl/rcpc_checker.sv
test/rc_pulse_capture_glitch_reject_core_tb.sv
